// ===== src/acct_pkg.sv =====
// ----------------------------------------------------------------------------
// acct_pkg
// Shared types and constants of the box-versus-cone culling core.
// ----------------------------------------------------------------------------
package acct_pkg;

  // Fixed field widths of the configuration registers
  localparam int unsigned AxisW     = 16;
  localparam int unsigned ReachW    = 23;
  localparam int unsigned ApertureW = 32;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 3;

  // Projection carries 14 fraction bits from the Q1.14 axis
  localparam int unsigned AxisFracW = 14;
  // Aperture sine and cosine carry 15 fraction bits
  localparam int unsigned AperFracW = 15;

  // Result word: flag positions from the lowest bit up
  localparam int unsigned OutTdataW = 8;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_APEX_X   = 3'd0,
    CFG_APEX_Y   = 3'd1,
    CFG_APEX_Z   = 3'd2,
    CFG_AXIS_X   = 3'd3,
    CFG_AXIS_Y   = 3'd4,
    CFG_AXIS_Z   = 3'd5,
    CFG_REACH    = 3'd6,
    CFG_APERTURE = 3'd7
  } cfg_reg_e;

endpackage

// ===== src/aabb_cone_cull_test_core.sv =====
// ----------------------------------------------------------------------------
// aabb_cone_cull_test_core
// Tests axis-aligned boxes against a spotlight cone through a bounding sphere.
// ----------------------------------------------------------------------------
// Throughput: one box per cycle while the output is not stalled; the two square-root
// pipelines, one root bit per stage, set the depth.
// A stalled output freezes the whole pipeline; bubbles are not squeezed out.
// Reset clears all valid bits and loads the cone registers with their defaults.
module aabb_cone_cull_test_core #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [acct_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [acct_pkg::CfgDataW-1:0]      cfg_data_i,
  // Box stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, angle_cull, front_cull, back_cull, zero pad
  output logic [acct_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned DW     = W + 1;
  localparam int unsigned VW     = W + 3;
  localparam int unsigned PW     = VW + acct_pkg::AxisW;
  localparam int unsigned P1W    = PW - acct_pkg::AxisFracW;
  localparam int unsigned DsqW   = 2 * W + 2;
  localparam int unsigned LtermW = 2 * W + 3;
  localparam int unsigned LsqW   = 2 * W + 4;
  localparam int unsigned PsqW   = 2 * P1W - 1;
  localparam int unsigned SqOutW = LsqW / 2;
  localparam int unsigned CqW    = acct_pkg::HalfW + SqOutW;
  localparam int unsigned PsW    = P1W + acct_pkg::HalfW + 1;
  localparam int unsigned CmpW   = PW + 24;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [W-1:0]                    apex_q [3];
  logic [acct_pkg::AxisW-1:0]      axis_q [3];
  logic [acct_pkg::ReachW-1:0]     reach_q;
  logic [acct_pkg::ApertureW-1:0]  aper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q[0] <= '0;
      apex_q[1] <= '0;
      apex_q[2] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= acct_pkg::AxisW'(16384);
      reach_q   <= '0;
      aper_q    <= {1'b1, {(acct_pkg::ApertureW-1){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (acct_pkg::cfg_reg_e'(cfg_idx_i))
        acct_pkg::CFG_APEX_X:   apex_q[0] <= cfg_data_i[W-1:0];
        acct_pkg::CFG_APEX_Y:   apex_q[1] <= cfg_data_i[W-1:0];
        acct_pkg::CFG_APEX_Z:   apex_q[2] <= cfg_data_i[W-1:0];
        acct_pkg::CFG_AXIS_X:   axis_q[0] <= cfg_data_i[acct_pkg::AxisW-1:0];
        acct_pkg::CFG_AXIS_Y:   axis_q[1] <= cfg_data_i[acct_pkg::AxisW-1:0];
        acct_pkg::CFG_AXIS_Z:   axis_q[2] <= cfg_data_i[acct_pkg::AxisW-1:0];
        acct_pkg::CFG_REACH:    reach_q   <= cfg_data_i[acct_pkg::ReachW-1:0];
        acct_pkg::CFG_APERTURE: aper_q    <= cfg_data_i[acct_pkg::ApertureW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: move everything unless a result waits downstream
  logic out_vld_q;
  logic en;

  assign en            = m_axis_tready | ~out_vld_q;
  assign s_axis_tready = en;

  // Valid bits of the fixed stages
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q;
  logic vld_sq_q [SqOutW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < SqOutW; i++) begin
        vld_sq_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld1_q      <= s_axis_tvalid;
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      vld4_q      <= vld3_q;
      vld5_q      <= vld4_q;
      vld_sq_q[0] <= vld5_q;
      for (int i = 1; i < SqOutW; i++) begin
        vld_sq_q[i] <= vld_sq_q[i-1];
      end
      vld6_q    <= vld_sq_q[SqOutW-1];
      out_vld_q <= vld6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: doubled extent and doubled apex-to-center vector
  logic signed [DW-1:0] d1_q [3];
  logic signed [VW-1:0] v1_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_s1
    logic signed [W-1:0]  mn, mx;
    logic signed [VW-1:0] mn_e, mx_e, ap_e;

    assign mn   = s_axis_tdata[i*W +: W];
    assign mx   = s_axis_tdata[(3+i)*W +: W];
    assign mn_e = VW'(mn);
    assign mx_e = VW'(mx);
    assign ap_e = VW'($signed(apex_q[i]));

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_q[i] <= DW'(mx) - DW'(mn);
        v1_q[i] <= mn_e + mx_e - (ap_e <<< 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and axis products
  logic [2*W-1:0]       ds2_q [3];
  logic [LtermW-1:0]    ls2_q [3];
  logic signed [PW-1:0] pp2_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_s2
    logic signed [2*DW-1:0] dd;
    logic signed [2*VW-1:0] vv;
    logic signed [PW-1:0]   va;

    assign dd = (2*DW)'(d1_q[i]) * (2*DW)'(d1_q[i]);
    assign vv = (2*VW)'(v1_q[i]) * (2*VW)'(v1_q[i]);
    assign va = PW'(v1_q[i]) * PW'($signed(axis_q[i]));

    always_ff @(posedge clk_i) begin
      if (en) begin
        ds2_q[i] <= dd[2*W-1:0];
        ls2_q[i] <= vv[LtermW-1:0];
        pp2_q[i] <= va;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum over the three axes
  logic [DsqW-1:0]      dsq3_q;
  logic [LsqW-1:0]      lsq3_q;
  logic signed [PW-1:0] p3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq3_q <= DsqW'(ds2_q[0]) + DsqW'(ds2_q[1]) + DsqW'(ds2_q[2]);
      lsq3_q <= LsqW'(ls2_q[0]) + LsqW'(ls2_q[1]) + LsqW'(ls2_q[2]);
      p3_q   <= pp2_q[0] + pp2_q[1] + pp2_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: square of the floored projection
  logic signed [P1W-1:0]   p1_s3;
  logic signed [2*P1W-1:0] p1sq;
  logic [PsqW-1:0]         psq4_q;
  logic [LsqW-1:0]         lsq4_q;
  logic [DsqW-1:0]         dsq4_q;
  logic signed [PW-1:0]    p4_q;

  assign p1_s3 = p3_q[PW-1:acct_pkg::AxisFracW];
  assign p1sq  = (2*P1W)'(p1_s3) * (2*P1W)'(p1_s3);

  always_ff @(posedge clk_i) begin
    if (en) begin
      psq4_q <= p1sq[PsqW-1:0];
      lsq4_q <= lsq3_q;
      dsq4_q <= dsq3_q;
      p4_q   <= p3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: off-axis distance squared, clamped at zero
  logic [PsqW-1:0]      lsq_ext;
  logic [LsqW-1:0]      off5_q;
  logic [LsqW-1:0]      dsq5_q;
  logic signed [PW-1:0] p5_q;

  assign lsq_ext = PsqW'(lsq4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      off5_q <= (psq4_q <= lsq_ext) ? LsqW'(lsq_ext - psq4_q) : '0;
      dsq5_q <= LsqW'(dsq4_q);
      p5_q   <= p4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: sphere radius and off-axis distance side by side
  logic [SqOutW-1:0] r_root, q_root;

  acct_sqrt_pipe #(.IN_W(LsqW)) u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (dsq5_q),
    .root_o (r_root)
  );

  acct_sqrt_pipe #(.IN_W(LsqW)) u_sqrt_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (off5_q),
    .root_o (q_root)
  );

  // Carry the projection alongside the roots
  logic signed [PW-1:0] p_sq_q [SqOutW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sq_q[0] <= p5_q;
      for (int i = 1; i < SqOutW; i++) begin
        p_sq_q[i] <= p_sq_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: aperture products, front and back tests
  logic signed [PW-1:0]   p_t;
  logic signed [P1W-1:0]  p1_t;
  logic signed [CmpW-1:0] p_cmp;
  logic [CmpW-1:0]        front_lim;
  logic [CmpW-1:0]        r_sh14;
  logic [CqW-1:0]         cq6_q;
  logic signed [PsW-1:0]  ps6_q;
  logic [SqOutW-1:0]      r6_q;
  logic                   front6_q, back6_q;

  assign p_t       = p_sq_q[SqOutW-1];
  assign p1_t      = p_t[PW-1:acct_pkg::AxisFracW];
  assign p_cmp     = CmpW'(p_t);
  assign r_sh14    = CmpW'(r_root) << acct_pkg::AxisFracW;
  assign front_lim = (CmpW'(r_root) + (CmpW'(reach_q) << 1)) << acct_pkg::AxisFracW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cq6_q    <= CqW'(aper_q[acct_pkg::ApertureW-1 -: acct_pkg::HalfW]) * CqW'(q_root);
      ps6_q    <= PsW'(p1_t) * PsW'($signed({1'b0, aper_q[acct_pkg::HalfW-1:0]}));
      r6_q     <= r_root;
      front6_q <= p_cmp > $signed(front_lim);
      back6_q  <= p_cmp < -$signed(r_sh14);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: aperture test and result register
  logic signed [CmpW-1:0] dc;
  logic [CmpW-1:0]        r_sh15;
  logic                   angle;
  logic                   hit_q, angle_q, front_q, back_q;

  assign dc     = $signed(CmpW'(cq6_q)) - CmpW'(ps6_q);
  assign r_sh15 = CmpW'(r6_q) << acct_pkg::AperFracW;
  assign angle  = dc > $signed(r_sh15);

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle;
      front_q <= front6_q;
      back_q  <= back6_q;
      hit_q   <= ~(angle | front6_q | back6_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, back_q, front_q, angle_q, hit_q};

  // --------------------------------------------------------------------------
  // Assertions
  a_hit_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (hit_q == !(angle_q || front_q || back_q)))
    else $error("hit disagrees with cull flags");

  a_front_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(front_q && back_q))
    else $error("front and back cull both set");

  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline is frozen");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && vld6_q) |=> vld6_q)
    else $error("inner stage lost an item during a stall");

endmodule

// ===== src/acct_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// acct_sqrt_pipe
// Pipelined integer square root, floor result, one root bit per stage.
// ----------------------------------------------------------------------------
module acct_sqrt_pipe #(
  parameter int unsigned IN_W = 52
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     rad_i,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int unsigned OutW = IN_W / 2;
  localparam int unsigned RemW = OutW + 2;

  logic [IN_W-1:0] rad_q  [OutW];
  logic [RemW-1:0] rem_q  [OutW];
  logic [OutW-1:0] root_q [OutW];

  for (genvar s = 0; s < OutW; s++) begin : g_stage
    logic [IN_W-1:0] rad_in;
    logic [RemW-1:0] rem_in;
    logic [OutW-1:0] root_in;
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RemW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_in[OutW-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_in[OutW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[OutW-1];

endmodule
